/* rtl/asa_pkg.sv */
package asa_pkg;

    // Sizing of the row table and the atlas
    localparam int MAX_ROWS     = 64;
    localparam int INITIAL_SIDE = 128;
    localparam int MAX_SIDE     = 4096;
    localparam int FIRST_TOP    = 3;

    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

    // Field widths
    localparam int COORD_W  = 12;
    localparam int SIDE_W   = 13;
    localparam int STATUS_W = 2;

    // floor(h / 10) as (h * 3277) >> 15, exact for h below 16384
    localparam int TENTH_MUL   = 3277;
    localparam int TENTH_SHIFT = 15;
    localparam int PROD_W      = 2 * COORD_W;

    // Ratio test: 10 * h >= 7 * row_height
    localparam int RATIO_NUM = 7;
    localparam int RATIO_DEN = 10;
    localparam int RATIO_W   = SIDE_W + 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXISTING = 2'd0,
        ST_NEW_ROW  = 2'd1,
        ST_FAIL     = 2'd2
    } place_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_GROW,
        S_COMMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // request beat accepted
        logic scan;       // walk the row table
        logic apply_hit;  // place in the chosen existing row
        logic grow_init;  // start side search from current side
        logic grow_step;  // double the trial side
        logic commit;     // open new row or report failure
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic out_free;
        logic grow_more;
    } dp_status_t;

endpackage

/* rtl/asa_ctrl.sv */
module asa_ctrl
    import asa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    state_next = status.found ? S_IDLE : S_GROW;
                end
            end
            S_GROW:
            begin
                if (!status.grow_more)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_DECIDE:
            begin
                cmd.apply_hit = status.out_free && status.found;
                cmd.grow_init = status.out_free && !status.found;
            end
            S_GROW:
            begin
                cmd.grow_step = status.grow_more;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/asa_dp.sv */
module asa_dp
    import asa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic [COORD_W-1:0]  rect_width,
    input  logic [COORD_W-1:0]  rect_height,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COORD_W-1:0]  place_left,
    output logic [COORD_W-1:0]  place_top,
    output logic [SIDE_W-1:0]   atlas_side,
    output logic                side_grew,
    output logic [STATUS_W-1:0] place_status
);

    localparam logic [SIDE_W:0] MAX_SIDE_X = (SIDE_W+1)'(MAX_SIDE);

    // Row table memories
    logic [COORD_W-1:0] top_mem  [MAX_ROWS];
    logic [SIDE_W-1:0]  high_mem [MAX_ROWS];
    logic [SIDE_W-1:0]  fill_mem [MAX_ROWS];

    // Control state
    logic [ROW_CNT_W-1:0] row_cnt_reg;
    logic [SIDE_W-1:0]    next_top_reg;
    logic [SIDE_W-1:0]    side_reg;
    logic [ROW_CNT_W-1:0] scan_idx_reg;
    logic                 rd_valid_reg;
    logic                 found_reg;
    logic                 out_valid_reg;

    // Request payload
    logic [COORD_W-1:0] w_reg;
    logic [COORD_W-1:0] h_reg;
    logic [SIDE_W-1:0]  row_h_reg;
    logic [SIDE_W:0]    side_work_reg;

    // Read stage
    logic [ROW_IDX_W-1:0] rd_idx_reg;
    logic [COORD_W-1:0]   rd_top_reg;
    logic [SIDE_W-1:0]    rd_high_reg;
    logic [SIDE_W-1:0]    rd_fill_reg;

    // Best row so far
    logic [ROW_IDX_W-1:0] best_idx_reg;
    logic [COORD_W-1:0]   best_top_reg;
    logic [SIDE_W-1:0]    best_high_reg;
    logic [SIDE_W-1:0]    best_fill_reg;

    // Output registers
    logic [COORD_W-1:0]  left_reg;
    logic [COORD_W-1:0]  top_out_reg;
    logic [SIDE_W-1:0]   side_out_reg;
    logic                grew_reg;
    place_status_t       status_reg;

    logic                 issue;
    logic                 eligible;
    logic [SIDE_W-1:0]    room;
    logic [RATIO_W-1:0]   h_scaled;
    logic [RATIO_W-1:0]   rh_scaled;
    logic [PROD_W-1:0]    tenth_prod;
    logic [SIDE_W-1:0]    row_h_next;
    logic [SIDE_W:0]      new_bottom;
    logic                 commit_fail;
    logic                 fill_we;
    logic [ROW_IDX_W-1:0] fill_addr;
    logic [SIDE_W-1:0]    fill_wdata;
    logic                 row_we;

    // Scan issue: one row read per cycle
    assign issue = cmd.scan && (scan_idx_reg != row_cnt_reg);

    // Row height of a new row: h + floor(h / 10)
    assign tenth_prod = PROD_W'(h_reg) * PROD_W'(TENTH_MUL);
    assign row_h_next = SIDE_W'(h_reg) + SIDE_W'(tenth_prod[PROD_W-1:TENTH_SHIFT]);

    // Eligibility of the row just read
    assign room      = (rd_fill_reg > side_reg) ? '0 : side_reg - rd_fill_reg;
    assign h_scaled  = RATIO_W'(h_reg) * RATIO_W'(RATIO_DEN);
    assign rh_scaled = RATIO_W'(rd_high_reg) * RATIO_W'(RATIO_NUM);
    assign eligible  = (h_scaled >= rh_scaled)
                    && (SIDE_W'(h_reg) <= rd_high_reg)
                    && (SIDE_W'(w_reg) <= room);

    // Side search and commit checks
    assign new_bottom  = (SIDE_W+1)'(next_top_reg) + (SIDE_W+1)'(row_h_reg);
    assign commit_fail = (row_cnt_reg >= ROW_CNT_W'(MAX_ROWS)) || (side_work_reg > MAX_SIDE_X);

    assign status.grow_more = (side_work_reg <= MAX_SIDE_X)
                           && ((new_bottom >= side_work_reg)
                               || ((SIDE_W+1)'(w_reg) >= side_work_reg));
    assign status.scan_done = (scan_idx_reg == row_cnt_reg) && !rd_valid_reg;
    assign status.found     = found_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // Memory write selection
    assign row_we = cmd.commit && !commit_fail;
    always_comb
    begin
        fill_we    = 1'b0;
        fill_addr  = best_idx_reg;
        fill_wdata = best_fill_reg + SIDE_W'(w_reg);
        if (cmd.apply_hit)
        begin
            fill_we = 1'b1;
        end
        else if (row_we)
        begin
            fill_we    = 1'b1;
            fill_addr  = row_cnt_reg[ROW_IDX_W-1:0];
            fill_wdata = SIDE_W'(w_reg);
        end
    end

    // Row memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_addr] <= fill_wdata;
        end
        if (row_we)
        begin
            top_mem[row_cnt_reg[ROW_IDX_W-1:0]]  <= next_top_reg[COORD_W-1:0];
            high_mem[row_cnt_reg[ROW_IDX_W-1:0]] <= row_h_reg;
        end
        if (issue)
        begin
            rd_top_reg  <= top_mem[scan_idx_reg[ROW_IDX_W-1:0]];
            rd_high_reg <= high_mem[scan_idx_reg[ROW_IDX_W-1:0]];
            rd_fill_reg <= fill_mem[scan_idx_reg[ROW_IDX_W-1:0]];
            rd_idx_reg  <= scan_idx_reg[ROW_IDX_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            next_top_reg  <= SIDE_W'(FIRST_TOP);
            side_reg      <= SIDE_W'(INITIAL_SIDE);
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (rd_valid_reg && eligible)
            begin
                found_reg <= 1'b1;
            end
            if (row_we)
            begin
                row_cnt_reg  <= row_cnt_reg + 1'b1;
                next_top_reg <= new_bottom[SIDE_W-1:0];
                side_reg     <= side_work_reg[SIDE_W-1:0];
            end
            if (cmd.apply_hit || cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload, best-row tracking and result beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg <= rect_width;
            h_reg <= rect_height;
        end
        if (cmd.scan)
        begin
            row_h_reg <= row_h_next;
        end
        if (rd_valid_reg && eligible && (!found_reg || rd_high_reg <= best_high_reg))
        begin
            best_idx_reg  <= rd_idx_reg;
            best_top_reg  <= rd_top_reg;
            best_high_reg <= rd_high_reg;
            best_fill_reg <= rd_fill_reg;
        end
        if (cmd.grow_init)
        begin
            side_work_reg <= (SIDE_W+1)'(side_reg);
        end
        else if (cmd.grow_step)
        begin
            side_work_reg <= side_work_reg << 1;
        end
        if (cmd.apply_hit)
        begin
            left_reg     <= best_fill_reg[COORD_W-1:0];
            top_out_reg  <= best_top_reg;
            side_out_reg <= side_reg;
            grew_reg     <= 1'b0;
            status_reg   <= ST_EXISTING;
        end
        else if (cmd.commit)
        begin
            left_reg <= '0;
            if (commit_fail)
            begin
                top_out_reg  <= '0;
                side_out_reg <= side_reg;
                grew_reg     <= 1'b0;
                status_reg   <= ST_FAIL;
            end
            else
            begin
                top_out_reg  <= next_top_reg[COORD_W-1:0];
                side_out_reg <= side_work_reg[SIDE_W-1:0];
                grew_reg     <= (side_work_reg[SIDE_W-1:0] != side_reg);
                status_reg   <= ST_NEW_ROW;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign place_left   = left_reg;
    assign place_top    = top_out_reg;
    assign atlas_side   = side_out_reg;
    assign side_grew    = grew_reg;
    assign place_status = status_reg;

    // A new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply_hit || cmd.commit) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    // The atlas side is always a power of two
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(side_reg))
        else $error("atlas side not a power of two");

    // The row table never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt_reg <= ROW_CNT_W'(MAX_ROWS))
        else $error("row count beyond capacity");

    // Opening a row adds exactly one row
    assert property (@(posedge clk) disable iff (!rst_n)
        row_we |=> (row_cnt_reg == $past(row_cnt_reg) + 1'b1))
        else $error("row count not advanced on new row");

endmodule

/* rtl/atlas_shelf_allocator_top.sv */
// Shelf allocator for a square texture atlas. Each request beat (rect_width,
// rect_height) gets one result beat: the placement (place_left, place_top),
// the atlas side after the request, whether the side grew, and a status
// (0 placed in an existing row, 1 new row opened, 2 no room). The row
// table lives in memories with a registered read and is read one row
// per cycle, and the side search doubles the side once per cycle (at
// most six steps). Row memories need no clearing after reset; the block
// takes a request right away. A result may wait at the output while the
// next request is accepted and scanned.
module atlas_shelf_allocator_top
    import asa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [COORD_W-1:0]  rect_width,
    input  logic [COORD_W-1:0]  rect_height,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COORD_W-1:0]  place_left,
    output logic [COORD_W-1:0]  place_top,
    output logic [SIDE_W-1:0]   atlas_side,
    output logic                side_grew,
    output logic [STATUS_W-1:0] place_status
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer
    asa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Row table, scan and placement
    asa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .place_left   (place_left),
        .place_top    (place_top),
        .atlas_side   (atlas_side),
        .side_grew    (side_grew),
        .place_status (place_status)
    );

endmodule
